// ===== hw/rtl/rbst_pkg.sv =====
// types and constants for the ray versus box slab test pipeline
// no dependencies; used by the channel interfaces, the top level and its checker
package rbst_pkg;

   localparam int COORD_W   = 32;
   localparam int DIR_W     = 16;
   localparam int DIFF_W    = 34;
   localparam int DIST_W    = 31;
   localparam int TOL_W     = 15;
   localparam int REM_W     = 16;
   localparam int QUO_W     = 32;
   localparam int DIV_STEPS = 32;
   localparam int AXES      = 3;
   localparam int LANES     = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_EXPAND     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_TOLERANCE = 2'd2;

   localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 31'h7FFF_FFFF;
   localparam logic [QUO_W-1:0]  SAT_POS = 32'h7FFF_FFFF;
   localparam logic [QUO_W-1:0]  SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic signed [DIR_W-1:0]   dir_z;
      logic signed [COORD_W-1:0] box_min_x;
      logic signed [COORD_W-1:0] box_min_y;
      logic signed [COORD_W-1:0] box_min_z;
      logic signed [COORD_W-1:0] box_max_x;
      logic signed [COORD_W-1:0] box_max_y;
      logic signed [COORD_W-1:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] entry_distance;
   } rsp_type;

   typedef struct packed {
      logic                          vld;
      logic [AXES-1:0]               dsign;
      logic [AXES-1:0]               par;
      logic [AXES-1:0][DIR_W-1:0]    dmag;
      logic [LANES-1:0][DIFF_W-1:0]  diff;
   } s1_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [DIR_W-1:0] dvs;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      logic                    vld;
      logic [AXES-1:0]         par;
      logic                    reject;
      lane_type [LANES-1:0]    lane;
   } div_type;

   typedef struct packed {
      logic                         vld;
      logic [AXES-1:0]              par;
      logic                         reject;
      logic [LANES-1:0][QUO_W-1:0]  q;
   } dist_type;

   typedef struct packed {
      logic             vld;
      logic             reject;
      logic [QUO_W-1:0] t_lo;
      logic [QUO_W-1:0] t_hi;
   } fold_type;

endpackage

// ===== hw/rtl/rbst_req_if.sv =====
// request channel: valid, ready and one ray/box query beat
// depends on rbst_pkg
interface rbst_req_if;
   logic             valid;
   logic             ready;
   rbst_pkg::req_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/rbst_rsp_if.sv =====
// response channel: valid, ready and one hit/entry distance beat
// depends on rbst_pkg
interface rbst_rsp_if;
   logic             valid;
   logic             ready;
   rbst_pkg::rsp_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/ray_box_slab_test.sv =====
// ray versus axis-aligned box slab test, fully pipelined
// depends on rbst_pkg, rbst_req_if and rbst_rsp_if
//
// Takes one query beat per cycle unless stalled and returns one response beat
// per query, in order. Six restoring dividers (two face distances per axis)
// retire one quotient bit per stage over 32 stages; two setup stages and three
// stages of saturation, sorting and interval folding surround them. A
// two-entry output buffer lets the pipeline keep accepting while a response
// waits; the request side stalls only when both entries are full.
module ray_box_slab_test (
   input  logic                                 clock,
   input  logic                                 reset,
   rbst_req_if.sink                             req_bus,
   rbst_rsp_if.source                           rsp_bus,
   input  logic                                 csr_wen,
   input  logic [rbst_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rbst_pkg::DIST_W-1:0]          csr_wdata
);

   logic [rbst_pkg::DIST_W-1:0] box_expand_ff;
   logic [rbst_pkg::DIST_W-1:0] max_distance_ff;
   logic [rbst_pkg::TOL_W-1:0]  zero_tolerance_ff;

   rbst_pkg::s1_type   s1_ff, s1_in;
   rbst_pkg::div_type  div_ff [0:rbst_pkg::DIV_STEPS];
   rbst_pkg::div_type  div_in [0:rbst_pkg::DIV_STEPS];
   rbst_pkg::dist_type post_ff, post_in;
   rbst_pkg::dist_type sort_ff, sort_in;
   rbst_pkg::fold_type fold_ff, fold_in;

   rbst_pkg::rsp_type  buf0_ff, buf0_in, buf1_ff, buf1_in, new_rsp;
   logic [1:0]         cnt_ff, cnt_in;
   logic               en, push, pop;

   function automatic rbst_pkg::lane_type div_step(rbst_pkg::lane_type l);
      rbst_pkg::lane_type res;
      logic [rbst_pkg::REM_W:0] r;
      logic [rbst_pkg::REM_W:0] t;
      res = l;
      r = {l.rem, l.quo[rbst_pkg::QUO_W-1]};
      t = r - {1'b0, l.dvs};
      if (r >= {1'b0, l.dvs}) begin
         res.rem = t[rbst_pkg::REM_W-1:0];
         res.quo = {l.quo[rbst_pkg::QUO_W-2:0], 1'b1};
      end else begin
         res.rem = r[rbst_pkg::REM_W-1:0];
         res.quo = {l.quo[rbst_pkg::QUO_W-2:0], 1'b0};
      end
      return res;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         box_expand_ff     <= '0;
         max_distance_ff   <= rbst_pkg::MAX_DISTANCE_RESET;
         zero_tolerance_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            rbst_pkg::CSR_BOX_EXPAND:     box_expand_ff     <= csr_wdata;
            rbst_pkg::CSR_MAX_DISTANCE:   max_distance_ff   <= csr_wdata;
            rbst_pkg::CSR_ZERO_TOLERANCE: zero_tolerance_ff <= csr_wdata[rbst_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   assign en            = (cnt_ff != 2'd2);
   assign req_bus.ready = en;

   // stage 1: face minus origin, direction magnitude, parallel flag
   always_comb begin
      logic signed [rbst_pkg::COORD_W-1:0] org [rbst_pkg::AXES];
      logic signed [rbst_pkg::COORD_W-1:0] bmin [rbst_pkg::AXES];
      logic signed [rbst_pkg::COORD_W-1:0] bmax [rbst_pkg::AXES];
      logic signed [rbst_pkg::DIR_W-1:0]   dir [rbst_pkg::AXES];
      logic [rbst_pkg::DIR_W-1:0]          mag;
      org[0]  = req_bus.data.origin_x;
      org[1]  = req_bus.data.origin_y;
      org[2]  = req_bus.data.origin_z;
      bmin[0] = req_bus.data.box_min_x;
      bmin[1] = req_bus.data.box_min_y;
      bmin[2] = req_bus.data.box_min_z;
      bmax[0] = req_bus.data.box_max_x;
      bmax[1] = req_bus.data.box_max_y;
      bmax[2] = req_bus.data.box_max_z;
      dir[0]  = req_bus.data.dir_x;
      dir[1]  = req_bus.data.dir_y;
      dir[2]  = req_bus.data.dir_z;
      s1_in.vld = req_bus.valid;
      for (int a = 0; a < rbst_pkg::AXES; a++) begin
         mag = dir[a][rbst_pkg::DIR_W-1] ? rbst_pkg::DIR_W'(-dir[a]) : dir[a];
         s1_in.dsign[a] = dir[a][rbst_pkg::DIR_W-1];
         s1_in.dmag[a]  = mag;
         s1_in.par[a]   = (mag <= {1'b0, zero_tolerance_ff});
         s1_in.diff[2*a] = {{2{bmin[a][rbst_pkg::COORD_W-1]}}, bmin[a]}
                         - {3'b000, box_expand_ff}
                         - {{2{org[a][rbst_pkg::COORD_W-1]}}, org[a]};
         s1_in.diff[2*a+1] = {{2{bmax[a][rbst_pkg::COORD_W-1]}}, bmax[a]}
                           + {3'b000, box_expand_ff}
                           - {{2{org[a][rbst_pkg::COORD_W-1]}}, org[a]};
      end
   end

   // stage 2: divider setup, slab reject for parallel axes
   always_comb begin
      logic [rbst_pkg::DIFF_W-1:0] d;
      logic [rbst_pkg::DIFF_W-1:0] am;
      logic [rbst_pkg::AXES-1:0]   rej;
      div_in[0].vld = s1_ff.vld;
      div_in[0].par = s1_ff.par;
      for (int j = 0; j < rbst_pkg::LANES; j++) begin
         d  = s1_ff.diff[j];
         am = d[rbst_pkg::DIFF_W-1] ? rbst_pkg::DIFF_W'(-d) : d;
         div_in[0].lane[j].dvs = s1_ff.dmag[j/2];
         div_in[0].lane[j].rem = am[rbst_pkg::DIFF_W-1:rbst_pkg::DIFF_W-rbst_pkg::REM_W];
         div_in[0].lane[j].quo = {am[rbst_pkg::DIFF_W-rbst_pkg::REM_W-1:0], 14'd0};
         div_in[0].lane[j].ovf = (am[rbst_pkg::DIFF_W-1:rbst_pkg::DIFF_W-rbst_pkg::REM_W]
                                  >= s1_ff.dmag[j/2]);
         div_in[0].lane[j].neg = d[rbst_pkg::DIFF_W-1] ^ s1_ff.dsign[j/2];
      end
      for (int a = 0; a < rbst_pkg::AXES; a++) begin
         rej[a] = s1_ff.par[a]
                  && ((!s1_ff.diff[2*a][rbst_pkg::DIFF_W-1] && (|s1_ff.diff[2*a]))
                      || s1_ff.diff[2*a+1][rbst_pkg::DIFF_W-1]);
      end
      div_in[0].reject = |rej;
   end

   // divider stages, one quotient bit each
   for (genvar k = 0; k < rbst_pkg::DIV_STEPS; k++) begin : g_div
      always_comb begin
         div_in[k+1].vld    = div_ff[k].vld;
         div_in[k+1].par    = div_ff[k].par;
         div_in[k+1].reject = div_ff[k].reject;
         for (int j = 0; j < rbst_pkg::LANES; j++) begin
            div_in[k+1].lane[j] = div_step(div_ff[k].lane[j]);
         end
      end
   end

   for (genvar k = 0; k <= rbst_pkg::DIV_STEPS; k++) begin : g_div_ff
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k].vld <= 1'b0;
         end else if (en) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // sign and saturation
   always_comb begin
      rbst_pkg::lane_type l;
      post_in.vld    = div_ff[rbst_pkg::DIV_STEPS].vld;
      post_in.par    = div_ff[rbst_pkg::DIV_STEPS].par;
      post_in.reject = div_ff[rbst_pkg::DIV_STEPS].reject;
      for (int j = 0; j < rbst_pkg::LANES; j++) begin
         l = div_ff[rbst_pkg::DIV_STEPS].lane[j];
         if (!l.neg) begin
            post_in.q[j] = (l.ovf || l.quo[rbst_pkg::QUO_W-1]) ? rbst_pkg::SAT_POS : l.quo;
         end else if (l.ovf || (l.quo > rbst_pkg::SAT_NEG)) begin
            post_in.q[j] = rbst_pkg::SAT_NEG;
         end else begin
            post_in.q[j] = rbst_pkg::QUO_W'(-l.quo);
         end
      end
   end

   // near and far distance per axis
   always_comb begin
      sort_in = post_ff;
      for (int a = 0; a < rbst_pkg::AXES; a++) begin
         if ($signed(post_ff.q[2*a]) > $signed(post_ff.q[2*a+1])) begin
            sort_in.q[2*a]   = post_ff.q[2*a+1];
            sort_in.q[2*a+1] = post_ff.q[2*a];
         end
      end
   end

   // fold into the running interval
   always_comb begin
      logic [rbst_pkg::QUO_W-1:0] lo_c, hi_c;
      fold_in.vld    = sort_ff.vld;
      fold_in.reject = sort_ff.reject;
      fold_in.t_lo   = '0;
      fold_in.t_hi   = {1'b0, max_distance_ff};
      for (int a = 0; a < rbst_pkg::AXES; a++) begin
         lo_c = sort_ff.par[a] ? '0 : sort_ff.q[2*a];
         hi_c = sort_ff.par[a] ? {1'b0, max_distance_ff} : sort_ff.q[2*a+1];
         if ($signed(lo_c) > $signed(fold_in.t_lo)) fold_in.t_lo = lo_c;
         if ($signed(hi_c) < $signed(fold_in.t_hi)) fold_in.t_hi = hi_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld   <= 1'b0;
         post_ff.vld <= 1'b0;
         sort_ff.vld <= 1'b0;
         fold_ff.vld <= 1'b0;
      end else if (en) begin
         s1_ff   <= s1_in;
         post_ff <= post_in;
         sort_ff <= sort_in;
         fold_ff <= fold_in;
      end
   end

   // two-entry output buffer
   always_comb begin
      new_rsp.hit = !fold_ff.reject && ($signed(fold_ff.t_lo) <= $signed(fold_ff.t_hi));
      new_rsp.entry_distance = new_rsp.hit ? fold_ff.t_lo[rbst_pkg::DIST_W-1:0] : '0;
      push    = en && fold_ff.vld;
      pop     = rsp_bus.valid && rsp_bus.ready;
      buf0_in = buf0_ff;
      buf1_in = buf1_ff;
      cnt_in  = cnt_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               buf0_in = new_rsp;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               buf0_in = new_rsp;
            end else if (push) begin
               buf1_in = new_rsp;
               cnt_in  = 2'd2;
            end else if (pop) begin
               cnt_in  = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               buf0_in = buf1_ff;
               cnt_in  = 2'd1;
            end
         end
         default: cnt_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf0_ff <= buf0_in;
      buf1_ff <= buf1_in;
   end

   assign rsp_bus.valid = (cnt_ff != 2'd0);
   assign rsp_bus.data  = buf0_ff;

endmodule

// ===== hw/rtl/rbst_checker.sv =====
// port-level assertions for ray_box_slab_test, attached by bind
// depends on rbst_pkg and the top level's ports
module rbst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_hit,
   input logic [rbst_pkg::DIST_W-1:0]   rsp_entry_distance
);

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_entry_distance == '0)
      else $error("miss with nonzero entry distance");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with no response waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
                                 && $stable(rsp_entry_distance))
      else $error("stalled response changed");

   a_req_no_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("request stalled with no response waiting");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_hit            (rsp_bus.data.hit),
   .rsp_entry_distance (rsp_bus.data.entry_distance)
);
